// File: rtl/sorted_array_table_defines.svh
// Assertion macros used by the sorted array table controller.
`ifndef SORTED_ARRAY_TABLE_DEFINES_SVH
`define SORTED_ARRAY_TABLE_DEFINES_SVH

// The condition must never be true outside reset.
`define SAT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sat_pkg.sv
// Shared types and constants for the sorted array table.
`timescale 1ns / 1ps

package sat_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} op_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} sat_cmd_t;

endpackage

// File: rtl/sat_datapath.sv
// Datapath of the sorted array table: key cells, count, capacity and result registers.
`timescale 1ns / 1ps

module sat_datapath #(
	parameter int DEPTH    = sat_pkg::DEPTH_DEF,
	parameter int KEY_BITS = sat_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sat_pkg::sat_cmd_t            cmd,
	input  logic                         cfg_valid,
	input  logic [$clog2(DEPTH+1)-1:0]   max_entries,
	input  logic [1:0]                   kind,
	input  logic [KEY_BITS-1:0]          key_value,
	input  logic [$clog2(DEPTH)-1:0]     position,
	output logic [KEY_BITS-1:0]          read_value,
	output logic [1:0]                   status,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count
);
	import sat_pkg::*;

	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [1:0]          kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [POS_W-1:0]    pos_q;
	logic [KEY_BITS-1:0] entries_q [DEPTH];
	logic [KEY_BITS-1:0] entries_d [DEPTH];
	logic [KEY_BITS-1:0] ins_val [DEPTH];
	logic [KEY_BITS-1:0] rem_val [DEPTH];
	logic [DEPTH-1:0]    ge;
	logic [DEPTH-1:0]    at;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [CNT_W-1:0]    max_entries_q;
	logic [CNT_W-1:0]    cap;
	logic                full;
	logic                pos_ok;
	logic [KEY_BITS-1:0] read_value_q;
	logic [KEY_BITS-1:0] rd_d;
	op_status_t          status_q;
	op_status_t          st_d;

	// Operation word captured when the controller accepts it.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			key_q  <= key_value;
			pos_q  <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= CNT_W'(DEPTH);
		end else if (cfg_valid) begin
			max_entries_q <= max_entries;
		end
	end

	assign cap    = (max_entries_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_entries_q;
	assign full   = (count_q >= cap);
	assign pos_ok = (CNT_W'(pos_q) < count_q);

	// Each cell compares its own key and picks its next value from itself or a neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ge[i] = (CNT_W'(i) < count_q) && !(entries_q[i] < key_q);
		assign at[i] = ge[i] || (CNT_W'(i) == count_q);

		if (i == 0) begin : g_first
			assign ins_val[i] = at[i] ? key_q : entries_q[i];
		end else begin : g_rest
			assign ins_val[i] = !at[i]  ? entries_q[i] :
			                    at[i-1] ? entries_q[i-1] : key_q;
		end

		if (i == DEPTH - 1) begin : g_last
			assign rem_val[i] = entries_q[i];
		end else begin : g_inner
			assign rem_val[i] = (CNT_W'(i) >= CNT_W'(pos_q)) ? entries_q[i+1] : entries_q[i];
		end
	end

	always_comb begin
		entries_d = entries_q;
		count_d   = count_q;
		rd_d      = '0;
		st_d      = ST_OK;
		case (op_kind_t'(kind_q))
			OP_INSERT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					entries_d = ins_val;
					count_d   = count_q + CNT_W'(1);
				end
			end
			OP_LOOKUP: begin
				if (pos_ok) begin
					rd_d = entries_q[pos_q];
				end
			end
			OP_REMOVE: begin
				if (!pos_ok) begin
					st_d = ST_RANGE;
				end else begin
					entries_d = rem_val;
					count_d   = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			entries_q    <= entries_d;
			read_value_q <= rd_d;
			status_q     <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// The count only moves when a new result is written, so it is the result's count.
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

// File: rtl/sat_ctrl.sv
// Controller of the sorted array table: operation sequencing and result word handshake.
`timescale 1ns / 1ps
`include "sorted_array_table_defines.svh"

module sat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sat_pkg::sat_cmd_t cmd
);
	import sat_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				// Execute only once the result register is free or being emptied.
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SAT_ASSERT_NEVER(a_load_exec_excl, cmd.load && cmd.exec, "load and exec in one cycle")
	`SAT_ASSERT_NEXT(a_load_to_exec, cmd.load, (state_q == S_EXEC) && !in_ready, "no exec after load")
	`SAT_ASSERT_NEXT(a_exec_gives_word, cmd.exec, out_valid_q, "result word missing after exec")
	`SAT_ASSERT_IMPLIES(a_no_overwrite, out_valid_q && !out_ready, !cmd.exec, "pending word overwritten")

endmodule

// File: rtl/sorted_array_table.sv
// Sorted array table top level: an ascending key table with insert, lookup and remove.
// Each operation word passes a capture step and then an execute step, which waits until the
// output register is free, runs the parallel compare and shift across all key cells and
// registers the result word; no new word is accepted until the execute step is done.
// Reset: arst_n clears the count, the controller and the output valid and sets the capacity
// to its reset value; key cells are not reset and are only read below the count.
`timescale 1ns / 1ps

module sorted_array_table #(
	parameter int DEPTH    = sat_pkg::DEPTH_DEF,
	parameter int KEY_BITS = sat_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write channel for the capacity register.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [$clog2(DEPTH+1)-1:0] max_entries,
	// Operation words.
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [KEY_BITS-1:0]        key_value,
	input  logic [$clog2(DEPTH)-1:0]   position,
	// Result words.
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [KEY_BITS-1:0]        read_value,
	output logic [1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] entry_count
);
	import sat_pkg::*;

	sat_cmd_t cmd;

	// The capacity register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller accepts a word while idle, even if the previous result word still
	// waits in the output register; the execute step then holds until that word is taken.
	sat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds every key in its own cell. An insert compares the new key against
	// all cells at once; the cell at the insertion point takes the new key, each cell past it
	// its lower neighbor; a remove makes each cell at or past the position take its upper neighbor.
	sat_datapath #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_valid   (cfg_valid),
		.max_entries (max_entries),
		.kind        (kind),
		.key_value   (key_value),
		.position    (position),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

// File: test/tb_sorted_array_table.sv
// Testbench for the sorted array table: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_sorted_array_table;

	import sat_pkg::*;

	// The block leaves kind 3 unused; it must answer with a zero word and status ok.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         TABLE_DEPTH = 16;
	localparam int         PHASES      = 10;
	localparam int         PHASE_WORDS = 125;

	// One result word as the block reports it.
	typedef struct packed {
		logic [31:0] rd;
		op_status_t  st;
		logic [4:0]  cnt;
	} table_result_t;

	// One row of the directed part. A row is either a capacity write or an operation
	// word; when typed is set, the expected result in the row is used as written.
	typedef struct packed {
		logic          cfg_row;
		logic [4:0]    cap;
		logic [1:0]    k;
		logic [31:0]   key;
		logic [3:0]    pos;
		logic          typed;
		table_result_t res;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  max_entries;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [31:0] key_value;
	logic [3:0]  position;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_value;
	logic [1:0]  status;
	logic [4:0]  entry_count;

	// Predictor state: our own copy of the sorted keys, the count and the capacity register.
	logic [31:0]   sorted_keys [TABLE_DEPTH];
	int            key_count;
	logic [4:0]    capacity_reg;
	table_result_t expected_results [$];
	int            error_count;
	int            burst_left;

	sorted_array_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.max_entries (max_entries),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key_value   (key_value),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Applies one operation word to the predicted table and returns the word the block
	// should give back. Capacities above the table depth act as the full depth.
	function automatic void predict_table_op(input logic [1:0] k, input logic [31:0] key,
			input logic [3:0] pos, output table_result_t res);
		int  cap;
		int  at;
		bit  found;
		res.rd = '0;
		res.st = ST_OK;
		cap = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
		case (k)
			OP_INSERT: begin
				if (key_count >= cap) begin
					res.st = ST_FULL;
				end else begin
					// The new key goes ahead of the first stored key that is not smaller,
					// so it lands in front of any older equal keys.
					at = key_count;
					found = 1'b0;
					for (int i = 0; i < key_count; i++) begin
						if (!found && !(sorted_keys[i] < key)) begin
							at = i;
							found = 1'b1;
						end
					end
					for (int i = key_count; i > at; i--)
						sorted_keys[i] = sorted_keys[i - 1];
					sorted_keys[at] = key;
					key_count++;
				end
			end
			OP_LOOKUP: begin
				// Positions at or past the count read as zero with status ok.
				if (pos < key_count)
					res.rd = sorted_keys[pos];
			end
			OP_REMOVE: begin
				if (pos >= key_count) begin
					res.st = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < key_count; i++)
						sorted_keys[i] = sorted_keys[i + 1];
					key_count--;
				end
			end
			default: begin
			end
		endcase
		res.cnt = key_count[4:0];
	endfunction

	// Sends one operation word. The sender works in bursts: at the end of a burst valid
	// may drop for a random gap, otherwise the next word follows right behind the last one.
	// The prediction is made at the edge where the word is accepted.
	task automatic send_word(input logic [1:0] k, input logic [31:0] key, input logic [3:0] pos,
			input logic use_typed, input table_result_t typed_res);
		int            gap;
		table_result_t res;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(40, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		kind      <= k;
		key_value <= key;
		position  <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_table_op(k, key, pos, res);
		if (use_typed)
			res = typed_res;
		expected_results.push_back(res);
	endtask

	// Capacity writes happen only with the table idle: every word answered and then a
	// further wait for anything still in the pipeline.
	task automatic write_capacity(input logic [4:0] cap);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		max_entries <= cap;
		cfg_valid   <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		capacity_reg = cap;
		burst_left   = 0;
	endtask

	// Random key: a mix of the two extremes, a narrow band that makes equal keys common,
	// and full-width values.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	// Random position: mostly inside the stored range, sometimes anywhere in the field.
	function automatic logic [3:0] pick_position();
		if (key_count > 0 && $urandom_range(0, 3) != 0)
			return 4'($urandom_range(0, key_count - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// Main stimulus: reset, the directed table, then random phases at several capacities.
	initial begin
		step_row_t     directed_rows [];
		logic [4:0]    phase_caps [PHASES];
		table_result_t no_result;
		logic [1:0]    k;
		int            w;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		max_entries <= 5'd16;
		in_valid    <= 1'b0;
		kind        <= OP_INSERT;
		key_value   <= '0;
		position    <= '0;
		error_count = 0;
		burst_left  = 0;
		key_count   = 0;
		capacity_reg = 5'd16;
		no_result   = '0;
		foreach (sorted_keys[i])
			sorted_keys[i] = '0;

		// The directed part walks the special cases: an empty table, the key extremes,
		// equal keys, reads and removes past the end, the unused kind, a capacity lowered
		// below the count, a zero capacity and a capacity above the table depth.
		directed_rows = '{
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd0,  1'b1, '{32'd0, ST_OK,    5'd0}},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd0,  1'b1, '{32'd0, ST_RANGE, 5'd0}},
			'{1'b0, 5'd0,  KIND_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1, '{32'd0, ST_OK,    5'd0}},
			'{1'b0, 5'd0,  OP_INSERT,   32'hFFFF_FFFF, 4'd15, 1'b1, '{32'd0, ST_OK,    5'd1}},
			'{1'b0, 5'd0,  OP_INSERT,   32'h0000_0000, 4'd0,  1'b1, '{32'd0, ST_OK,    5'd2}},
			'{1'b0, 5'd0,  OP_INSERT,   32'h0000_0000, 4'd9,  1'b1, '{32'd0, ST_OK,    5'd3}},
			'{1'b0, 5'd0,  OP_INSERT,   32'h8000_0000, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'hFFFF_FFFF, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd1,  1'b0, '0},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd3,  1'b0, '0},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd15, 1'b1, '{32'd0, ST_OK,    5'd4}},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd15, 1'b1, '{32'd0, ST_RANGE, 5'd4}},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd0,  1'b0, '0},
			'{1'b1, 5'd1,  OP_INSERT,   32'h0000_0000, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_INSERT,   32'h0000_0005, 4'd0,  1'b1, '{32'd0, ST_FULL,  5'd3}},
			'{1'b1, 5'd0,  OP_INSERT,   32'h0000_0000, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd2,  1'b0, '0},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_INSERT,   32'h0000_0007, 4'd0,  1'b1, '{32'd0, ST_FULL,  5'd1}},
			'{1'b1, 5'd31, OP_INSERT,   32'h0000_0000, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_INSERT,   32'h0000_0007, 4'd0,  1'b0, '0},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd1,  1'b0, '0},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd1,  1'b0, '0},
			'{1'b0, 5'd0,  OP_REMOVE,   32'h0000_0000, 4'd0,  1'b1, '{32'd0, ST_OK,    5'd0}},
			'{1'b0, 5'd0,  OP_LOOKUP,   32'h0000_0000, 4'd0,  1'b1, '{32'd0, ST_OK,    5'd0}}
		};

		// Capacities for the random phases. Even phases lean toward inserts and fill the
		// table, odd ones lean toward removes, so a capacity often lands below the count.
		phase_caps = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd24, 5'd8, 5'd31, 5'd2, 5'd16};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd16);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg_row)
				write_capacity(directed_rows[i].cap);
			else
				send_word(directed_rows[i].k, directed_rows[i].key, directed_rows[i].pos,
					directed_rows[i].typed, directed_rows[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				w = $urandom_range(0, 99);
				if (p % 2 == 0)
					k = (w < 60) ? OP_INSERT : (w < 80) ? OP_LOOKUP :
						(w < 95) ? OP_REMOVE : KIND_UNUSED;
				else
					k = (w < 20) ? OP_INSERT : (w < 50) ? OP_LOOKUP :
						(w < 95) ? OP_REMOVE : KIND_UNUSED;
				// Ignored fields still carry random values.
				send_word(k, pick_key(), pick_position(), 1'b0, no_result);
			end
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// Keep the clock running so that any stray result word is still caught.
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Result side: the receiver switches between always ready, random stalls, mostly ready and a
	// rotating pattern of its own, each for a random stretch of cycles.
	initial begin
		int         stall_mode;
		logic [7:0] stall_pattern;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_mode    = $urandom_range(0, 3);
			stall_pattern = 8'($urandom) | 8'h01;
			repeat ($urandom_range(16, 96)) begin
				@(posedge clk);
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: begin
						out_ready     <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
					end
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Every accepted result word is compared with the oldest expected one.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: read_value %h status %0d count %0d",
					read_value, status, entry_count);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (read_value !== want.rd) begin
					$error("read_value: expected %h, got %h", want.rd, read_value);
					error_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					error_count++;
				end
				if (entry_count !== want.cnt) begin
					$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
					error_count++;
				end
			end
		end
	end

endmodule
